// ===== design/dsx_pkg.sv =====
`timescale 1ns / 1ps

package dsx_pkg;

  localparam logic [2:0] REG_BPP         = 3'd0;
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM_UP   = 3'd3;
  localparam logic [2:0] REG_START_LINE  = 3'd4;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd5;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd6;

  localparam logic [2:0] FMT_32 = 3'd0;
  localparam logic [2:0] FMT_24 = 3'd1;
  localparam logic [2:0] FMT_16 = 3'd2;
  localparam logic [2:0] FMT_8  = 3'd3;
  localparam logic [2:0] FMT_4  = 3'd4;
  localparam logic [2:0] FMT_1  = 3'd5;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [7:0]  data;
    logic        ok0;
    logic        ok1;
    logic [23:0] rgb;
    logic [11:0] col;
    logic [11:0] row;
    logic [2:0]  last_idx;
  } pix_job_t;

  // Scales a 5-bit channel by 255/31, rounded down: c*8 plus floor(c*7/31).
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] f;
    f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
      + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + {5'b00000, f};
  endfunction

endpackage

// ===== design/dib_scanline_to_xrgb32.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  tdata, tuser = mode, tlast = last of block
// m_axis   out        m_axis_tvalid/m_axis_tready  tdata, tlast = last pixel of the byte
// cfg      in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One beat per cycle when the output is not stalled, for bytes giving at most one pixel;
// 4 bpp and 1 bpp bytes hold input until their pixels pass the single pixel output register.
// Palette lookups use two registered read ports of the palette RAM, read in the cycle after the beat.
// Reset is synchronous; the palette is not cleared and s_axis_tready is held low after
// reset and after each register write while the stride is recomputed.
// A stalled output holds the pixel register and, while the current byte is not yet drained, input.

module dib_scanline_to_xrgb32 #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // pixel_value[31:0], column[43:32], row[55:44]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import dsx_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = WW + 2;
  localparam int CW  = (WW > 13) ? WW : 13;
  localparam int LW  = SW + 3;
  localparam int DW  = (CW > LW) ? CW : LW;
  localparam int PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [2:0]  bpp_code;
  logic [12:0] src_width;
  logic [12:0] src_height;
  logic        bottom_up;
  logic [11:0] start_line;
  logic [12:0] dest_width;
  logic [12:0] dest_height;
  logic        cfg_accept;
  logic        cfg_settle;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_code    <= FMT_32;
      src_width   <= 13'd1;
      src_height  <= 13'd1;
      bottom_up   <= 1'b1;
      start_line  <= 12'd0;
      dest_width  <= 13'd1;
      dest_height <= 13'd1;
      cfg_settle  <= 1'b1;
    end else begin
      cfg_settle <= cfg_accept;
      if (cfg_accept) begin
        case (cfg_index)
          REG_BPP:         bpp_code    <= cfg_data[2:0];
          REG_SRC_WIDTH:   src_width   <= cfg_data;
          REG_SRC_HEIGHT:  src_height  <= cfg_data;
          REG_BOTTOM_UP:   bottom_up   <= cfg_data[0];
          REG_START_LINE:  start_line  <= cfg_data[11:0];
          REG_DEST_WIDTH:  dest_width  <= cfg_data;
          REG_DEST_HEIGHT: dest_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Effective width, visible column limit and row stride in bytes.
  logic [CW-1:0]   sw_ext;
  logic [WW-1:0]   w_eff;
  logic [DW-1:0]   lim_comb;
  logic [DW-1:0]   lim;
  logic [SW-1:0]   stride_comb;
  logic [SW-1:0]   stride;
  logic [WW+1:0]   t24;
  logic [WW:0]     t16;
  logic [WW+1:0]   t8;
  logic [WW+2:0]   t4;
  logic [WW+4:0]   t1;

  assign sw_ext = CW'(src_width);

  always_comb begin
    if (src_width == 13'd0) begin
      w_eff = WW'(1);
    end else if (sw_ext > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(sw_ext);
    end
    if (DW'(w_eff) < DW'(dest_width)) begin
      lim_comb = DW'(w_eff);
    end else begin
      lim_comb = DW'(dest_width);
    end
    t24 = {2'b00, w_eff} + {1'b0, w_eff, 1'b0} + (WW+2)'(3);
    t16 = {1'b0, w_eff} + (WW+1)'(1);
    t8  = {2'b00, w_eff} + (WW+2)'(3);
    t4  = {3'b000, w_eff} + (WW+3)'(7);
    t1  = {5'b00000, w_eff} + (WW+5)'(31);
    case (bpp_code)
      FMT_24:  stride_comb = {t24[WW+1:2], 2'b00};
      FMT_16:  stride_comb = {t16[WW:1], 2'b00};
      FMT_8:   stride_comb = {t8[WW+1:2], 2'b00};
      FMT_4:   stride_comb = {t4[WW+2:3], 2'b00};
      FMT_1:   stride_comb = {t1[WW+4:5], 2'b00};
      default: stride_comb = {w_eff, 2'b00};
    endcase
  end

  always_ff @(posedge clk) begin
    stride <= stride_comb;
    lim    <= lim_comb;
  end

  // Stream position. ph3 and x3 track byte_pos modulo 3 and divided by 3.
  logic [SW-1:0] byte_pos;
  logic [11:0]   line_count;
  logic [23:0]   held;
  logic [1:0]    ph3;
  logic [SW-2:0] x3;

  logic        in_accept;
  logic        in_mode;
  logic [7:0]  pal_idx;
  logic [23:0] pal_color;
  logic [7:0]  data;
  logic        data_beat;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_mode   = s_axis_tuser;
  assign pal_idx   = s_axis_tdata[7:0];
  assign pal_color = s_axis_tdata[31:8];
  assign data      = s_axis_tdata[39:32];
  assign data_beat = in_accept && (in_mode == MODE_DATA);

  logic [12:0]        row_sum;
  logic signed [14:0] y;
  logic               visible;
  logic               direct;
  logic [1:0]         phase;
  logic [1:0]         last_phase;
  logic [SW-1:0]      px_x;
  logic [23:0]        held_next;
  logic [15:0]        c16;
  logic [23:0]        rgb;
  logic [DW-1:0]      base;
  logic [DW-1:0]      diff;
  logic [3:0]         span;
  logic [3:0]         n_pix;
  logic [7:0]         rd_idx0;
  logic [7:0]         rd_idx1;
  logic               ok0;
  logic               ok1;
  logic               wr_ok;
  logic               row_end;

  always_comb begin
    row_sum = {1'b0, start_line} + {1'b0, line_count};
    if (bottom_up) begin
      y = $signed({2'b00, src_height}) - 15'sd1 - $signed({2'b00, row_sum});
    end else begin
      y = $signed({2'b00, row_sum});
    end
    visible = !y[14] && (y[13:0] < {1'b0, dest_height});
    direct  = !(bpp_code inside {FMT_8, FMT_4, FMT_1});

    case (bpp_code)
      FMT_24: begin
        phase      = ph3;
        last_phase = 2'd2;
        px_x       = SW'(x3);
      end
      FMT_16: begin
        phase      = {1'b0, byte_pos[0]};
        last_phase = 2'd1;
        px_x       = SW'(byte_pos[SW-1:1]);
      end
      default: begin
        phase      = byte_pos[1:0];
        last_phase = 2'd3;
        px_x       = SW'(byte_pos[SW-1:2]);
      end
    endcase

    held_next = held;
    case (phase)
      2'd0:    held_next[7:0]   = data;
      2'd1:    held_next[15:8]  = data;
      2'd2:    held_next[23:16] = data;
      default: ;
    endcase

    c16 = {data, held_next[7:0]};
    case (bpp_code)
      FMT_32, FMT_24: rgb = held_next;
      FMT_16:  rgb = {expand5(c16[14:10]), expand5(c16[9:5]), expand5(c16[4:0])};
      default: rgb = 24'd0;
    endcase

    case (bpp_code)
      FMT_8: begin
        base = DW'(byte_pos);
        span = 4'd1;
      end
      FMT_4: begin
        base = DW'({byte_pos, 1'b0});
        span = 4'd2;
      end
      FMT_1: begin
        base = DW'({byte_pos, 3'b000});
        span = 4'd8;
      end
      default: begin
        base = DW'(px_x);
        span = (phase == last_phase) ? 4'd1 : 4'd0;
      end
    endcase

    diff = lim - base;
    if (!visible || span == 4'd0 || lim <= base) begin
      n_pix = 4'd0;
    end else if (diff >= DW'(span)) begin
      n_pix = span;
    end else begin
      n_pix = diff[3:0];
    end

    case (bpp_code)
      FMT_4: begin
        rd_idx0 = {4'h0, data[7:4]};
        rd_idx1 = {4'h0, data[3:0]};
      end
      FMT_1: begin
        rd_idx0 = 8'd0;
        rd_idx1 = 8'd1;
      end
      default: begin
        rd_idx0 = data;
        rd_idx1 = data;
      end
    endcase
    ok0   = {1'b0, rd_idx0} < 9'(PALETTE_ENTRIES);
    ok1   = {1'b0, rd_idx1} < 9'(PALETTE_ENTRIES);
    wr_ok = {1'b0, pal_idx} < 9'(PALETTE_ENTRIES);

    row_end = ({1'b0, byte_pos} + (SW+1)'(1)) >= {1'b0, stride};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      line_count <= 12'd0;
      held       <= 24'd0;
      ph3        <= 2'd0;
      x3         <= '0;
    end else if (data_beat) begin
      if (s_axis_tlast) begin
        byte_pos   <= '0;
        line_count <= 12'd0;
        held       <= 24'd0;
        ph3        <= 2'd0;
        x3         <= '0;
      end else begin
        if (direct) begin
          held <= held_next;
        end
        if (row_end) begin
          byte_pos   <= '0;
          line_count <= line_count + 12'd1;
          ph3        <= 2'd0;
          x3         <= '0;
        end else begin
          byte_pos <= byte_pos + SW'(1);
          if (ph3 == 2'd2) begin
            ph3 <= 2'd0;
            x3  <= x3 + (SW-1)'(1);
          end else begin
            ph3 <= ph3 + 2'd1;
          end
        end
      end
    end
  end

  // Palette RAM: one write port, two registered read ports.
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] rd0;
  logic [23:0] rd1;

  always_ff @(posedge clk) begin
    if (in_accept && (in_mode == MODE_PALETTE) && wr_ok) begin
      pal_mem[PAW'(pal_idx)] <= pal_color;
    end
    if (data_beat) begin
      rd0 <= pal_mem[PAW'(rd_idx0)];
      rd1 <= pal_mem[PAW'(rd_idx1)];
    end
  end

  // Pixel job for the byte just taken, drained one pixel per cycle while the output is not stalled.
  pix_job_t    job;
  pix_job_t    job_next;
  logic        job_valid;
  logic [2:0]  job_idx;
  logic        load_job;
  logic        out_free;
  logic        emit;
  logic        job_last;
  logic        job_done;
  logic [23:0] pix;

  always_comb begin
    job_next.fmt      = bpp_code;
    job_next.data     = data;
    job_next.ok0      = ok0;
    job_next.ok1      = ok1;
    job_next.rgb      = rgb;
    job_next.col      = base[11:0];
    job_next.row      = y[11:0];
    job_next.last_idx = 3'(n_pix - 4'd1);
  end

  assign load_job      = data_beat && (n_pix != 4'd0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = job_valid && out_free;
  assign job_last      = (job_idx == job.last_idx);
  assign job_done      = emit && job_last;
  assign s_axis_tready = !cfg_settle && (!job_valid || job_done);

  always_comb begin
    case (job.fmt)
      FMT_8:   pix = job.ok0 ? rd0 : 24'd0;
      FMT_4: begin
        if (job_idx[0]) begin
          pix = job.ok1 ? rd1 : 24'd0;
        end else begin
          pix = job.ok0 ? rd0 : 24'd0;
        end
      end
      FMT_1:   pix = job.data[3'd7 - job_idx] ? rd1 : rd0;
      default: pix = job.rgb;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= 3'd0;
    end else if (load_job) begin
      job_valid <= 1'b1;
      job_idx   <= 3'd0;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (emit) begin
      job_idx <= job_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      job <= job_next;
    end
  end

  logic [31:0] out_pixel;
  logic [11:0] out_col;
  logic [11:0] out_row;
  logic        out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel <= {ALPHA_OPAQUE, pix};
      out_col   <= job.col + {9'd0, job_idx};
      out_row   <= job.row;
      out_last  <= job_last;
    end
  end

  assign m_axis_tdata = {out_row, out_col, out_pixel};
  assign m_axis_tlast = out_last;

  ast_job_index: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_idx <= job.last_idx))
    else $error("pixel index ran past the last pixel of the byte");

  ast_job_restart: assert property (@(posedge clk) disable iff (rst)
    job_done |=> (!job_valid || (job_idx == 3'd0)))
    else $error("a new byte did not start at its first pixel");

  ast_mod3_track: assert property (@(posedge clk) disable iff (rst)
    (32'(x3) * 32'd3 + 32'(ph3)) == 32'(byte_pos))
    else $error("modulo-3 position counters out of step with byte position");

endmodule

// ===== verif/dib_pixel_checker.sv =====
`timescale 1ns / 1ps

module dib_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,  // pixel_value[31:0], column[43:32], row[55:44]
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  import dsx_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } xrgb_pixel_t;

  logic [2:0]  fmt;
  logic [12:0] src_width;
  logic [12:0] src_height;
  logic        bottom_up;
  logic [11:0] start_line;
  logic [12:0] dest_width;
  logic [12:0] dest_height;
  int          byte_pos;
  logic [11:0] line_count;
  logic [23:0] held;
  logic [23:0] palette [0:255];

  xrgb_pixel_t expected_pixels [$];
  xrgb_pixel_t run_buf [8];
  int          run_len;
  int          fail_count = 0;

  function automatic logic [7:0] scale5(input logic [4:0] c);
    return 8'((int'(c) * 255) / 31);
  endfunction

  task automatic emit_pixel(input int x, input int w, input int y, input logic [23:0] rgb);
    if (x < w && x < int'(dest_width)) begin
      run_buf[run_len] = '{{ALPHA_OPAQUE, rgb}, 12'(x), 12'(y), 1'b0};
      run_len++;
    end
  endtask

  task automatic apply_reg(input logic [2:0] index, input logic [12:0] value);
    case (index)
      REG_BPP:         fmt = value[2:0];
      REG_SRC_WIDTH:   src_width = value;
      REG_SRC_HEIGHT:  src_height = value;
      REG_BOTTOM_UP:   bottom_up = value[0];
      REG_START_LINE:  start_line = value[11:0];
      REG_DEST_WIDTH:  dest_width = value;
      REG_DEST_HEIGHT: dest_height = value;
      default: ;
    endcase
  endtask

  task automatic unpack_byte(input logic [39:0] beat, input logic mode, input logic last);
    int w, bits, k, m, stride, b, line, y, i;
    logic [7:0]  db;
    logic [15:0] c;
    logic        visible;
    if (mode == MODE_PALETTE) begin
      palette[beat[7:0]] = beat[31:8];
    end else begin
      db = beat[39:32];
      w = (src_width == 0) ? 1 : ((src_width > 13'd4096) ? 4096 : int'(src_width));
      case (fmt)
        FMT_24:  bits = 24;
        FMT_16:  bits = 16;
        FMT_8:   bits = 8;
        FMT_4:   bits = 4;
        FMT_1:   bits = 1;
        default: bits = 32;
      endcase
      stride = ((w * bits + 31) / 32) * 4;
      b = byte_pos;
      line = int'(start_line) + int'(line_count);
      y = bottom_up ? int'(src_height) - 1 - line : line;
      visible = (y >= 0) && (y < int'(dest_height));
      run_len = 0;
      case (fmt)
        FMT_8: begin
          if (visible) emit_pixel(b, w, y, palette[db]);
        end
        FMT_4: begin
          if (visible) begin
            emit_pixel(2 * b, w, y, palette[db[7:4]]);
            emit_pixel(2 * b + 1, w, y, palette[db[3:0]]);
          end
        end
        FMT_1: begin
          if (visible) begin
            for (i = 0; i < 8; i++) emit_pixel(8 * b + i, w, y, palette[{7'd0, db[7 - i]}]);
          end
        end
        default: begin
          // Direct formats and unsupported depths, which step like 32 bpp but give black.
          k = bits / 8;
          m = b % k;
          if (m < 3) held[m * 8 +: 8] = db;
          if (m == k - 1 && visible) begin
            c = {db, held[7:0]};
            if (fmt == FMT_16) begin
              emit_pixel(b / k, w, y, {scale5(c[14:10]), scale5(c[9:5]), scale5(c[4:0])});
            end else if (fmt == FMT_32 || fmt == FMT_24) begin
              emit_pixel(b / k, w, y, held);
            end else begin
              emit_pixel(b / k, w, y, 24'h000000);
            end
          end
        end
      endcase
      if (run_len > 0) run_buf[run_len - 1].last = 1'b1;
      for (i = 0; i < run_len; i++) expected_pixels.push_back(run_buf[i]);
      if (b + 1 >= stride) begin
        byte_pos = 0;
        line_count = line_count + 12'd1;
      end else begin
        byte_pos = b + 1;
      end
      if (last) begin
        byte_pos = 0;
        line_count = '0;
        held = '0;
      end
    end
  endtask

  task automatic check_pixel();
    xrgb_pixel_t got, want;
    got = '{m_axis_tdata[31:0], m_axis_tdata[43:32], m_axis_tdata[55:44], m_axis_tlast};
    if (expected_pixels.size() == 0) begin
      fail_count++;
      $display("%0t: expected no pixel, got %h col %0d row %0d last %0b", $time,
               got.value, got.column, got.row, got.last);
    end else begin
      want = expected_pixels.pop_front();
      if (got.value !== want.value || got.column !== want.column ||
          got.row !== want.row || got.last !== want.last) begin
        fail_count++;
        $display("%0t: expected pixel %h col %0d row %0d last %0b,", $time,
                 want.value, want.column, want.row, want.last,
                 " got %h col %0d row %0d last %0b",
                 got.value, got.column, got.row, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_32;
      src_width <= 13'd1;
      src_height <= 13'd1;
      bottom_up <= 1'b1;
      start_line <= '0;
      dest_width <= 13'd1;
      dest_height <= 13'd1;
      byte_pos <= 0;
      line_count <= '0;
      held <= '0;
      expected_pixels.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_pixel();
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) unpack_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    mismatches <= fail_count;
    pending <= expected_pixels.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dsx_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_ITEMS   = 135;
  localparam logic [2:0] FMT_NONE = 3'd6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // palette_index[7:0], palette_color[31:8], data_byte[39:32]
  logic        s_axis_tuser = MODE_DATA;  // mode
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // pixel_value[31:0], column[43:32], row[55:44]
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_BPP;
  logic [12:0] cfg_data = '0;

  int mismatches;
  int pending;
  bit calm = 1'b0;
  int rx_hold = 0;
  int rx_roll;
  int idle_cycles = 0;
  int items_sent = 0;
  int random_start;
  int n;

  logic [2:0] ph_fmt;
  int ph_sw, ph_sh, ph_bu, ph_sl, ph_dw, ph_dh, ph_count, ph_roll;
  bit ph_last;

  dib_scanline_to_xrgb32 DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  dib_pixel_checker pixel_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold <= (rx_roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dib_scanline_to_xrgb32 regression: fail");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic int stride_bytes(input logic [2:0] fmt, input int sw);
    int w, bits;
    w = (sw == 0) ? 1 : ((sw > 4096) ? 4096 : sw);
    case (fmt)
      FMT_24:  bits = 24;
      FMT_16:  bits = 16;
      FMT_8:   bits = 8;
      FMT_4:   bits = 4;
      FMT_1:   bits = 1;
      default: bits = 32;
    endcase
    return ((w * bits + 31) / 32) * 4;
  endfunction

  task automatic send_beat(input logic mode, input logic [7:0] pidx, input logic [23:0] pcol,
                           input logic [7:0] db, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {db, pcol, pidx};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [23:0] color);
    send_beat(MODE_PALETTE, idx, color, 8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  task automatic send_stream(input int count, input bit with_last, input bit extremes,
                             input int pal_chance);
    int i;
    logic [7:0] db;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < pal_chance) write_palette(8'($urandom), 24'($urandom));
      db = extremes ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom);
      send_beat(MODE_DATA, 8'($urandom), 24'($urandom), db, with_last && (i == count - 1));
    end
  endtask

  task automatic wait_idle(input int cycles);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= 13'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] fmt, input int sw, sh, bu, sl, dw, dh);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_BPP, int'(fmt));
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_BOTTOM_UP, bu);
    write_reg(REG_START_LINE, sl);
    write_reg(REG_DEST_WIDTH, dw);
    write_reg(REG_DEST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    calm <= ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every palette entry is loaded before any indexed byte can look one up.
    for (n = 0; n < 256; n++) begin
      write_palette(8'(n), (n == 0) ? 24'h000000 : ((n == 255) ? 24'hFFFFFF : 24'($urandom)));
    end

    configure(FMT_32, 1, 4096, 1, 4095, 4096, 4096);
    send_stream(4, 1'b1, 1'b1, 0);
    configure(FMT_24, 1, 1, 1, 0, 1, 1);
    send_stream(3, 1'b1, 1'b0, 0);
    configure(FMT_16, 1, 1, 0, 0, 2, 1);
    send_stream(2, 1'b1, 1'b1, 0);
    configure(FMT_8, 0, 1, 1, 0, 1, 1);
    send_stream(4, 1'b1, 1'b0, 0);
    configure(FMT_4, 3, 2, 1, 0, 4, 2);
    send_stream(2, 1'b1, 1'b0, 0);
    configure(FMT_1, 9, 1, 0, 0, 4096, 1);
    send_stream(2, 1'b1, 1'b0, 0);
    configure(FMT_NONE, 1, 1, 1, 0, 1, 1);
    send_stream(4, 1'b1, 1'b1, 0);
    configure(FMT_8, 1, 0, 1, 0, 1, 1);
    send_stream(2, 1'b1, 1'b0, 0);
    configure(FMT_8, 1, 4096, 0, 4095, 1, 8191);
    send_stream(5, 1'b1, 1'b0, 0);
    configure(FMT_8, 5000, 1, 1, 0, 8191, 1);
    send_stream(1, 1'b1, 1'b0, 0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      ph_fmt = 3'($urandom_range(0, 7));
      ph_roll = $urandom_range(0, 99);
      if (ph_roll < 85) begin
        ph_sw = $urandom_range(1, 12);
      end else begin
        case ($urandom_range(0, 3))
          0:       ph_sw = 0;
          1:       ph_sw = 4096;
          2:       ph_sw = 8191;
          default: ph_sw = $urandom_range(13, 8191);
        endcase
      end
      ph_roll = $urandom_range(0, 99);
      ph_sh = (ph_roll < 10) ? 0 : ((ph_roll < 95) ? $urandom_range(1, 4) : 4096);
      ph_bu = $urandom_range(0, 1);
      ph_sl = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(0, 4095);
      ph_roll = $urandom_range(0, 99);
      ph_dw = (ph_roll < 75) ? $urandom_range(1, 16) :
              ((ph_roll < 90) ? 4096 : $urandom_range(1, 8191));
      ph_roll = $urandom_range(0, 99);
      ph_dh = (ph_roll < 75) ? $urandom_range(1, 6) :
              ((ph_roll < 90) ? 4096 : $urandom_range(1, 8191));

      ph_count = stride_bytes(ph_fmt, ph_sw) *
                 ((ph_sh >= 1 && ph_sh <= 4) ? ph_sh : $urandom_range(1, 3));
      if (ph_count > 48) ph_count = $urandom_range(4, 48);
      ph_roll = $urandom_range(0, 99);
      ph_last = 1'b1;
      if (ph_roll < 12) begin
        ph_count = $urandom_range(1, ph_count);
      end else if (ph_roll < 22) begin
        ph_last = 1'b0;
      end

      configure(ph_fmt, ph_sw, ph_sh, ph_bu, ph_sl, ph_dw, ph_dh);
      send_stream(ph_count, ph_last, 1'b0, 8);
    end

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("dib_scanline_to_xrgb32 regression: pass");
    end else begin
      $display("dib_scanline_to_xrgb32 regression: fail");
    end
    $finish;
  end

endmodule
